// ===== hdl/slh_pkg.sv =====
// Shared types, constants and helpers for the slot latency histogram statistics block.
// No dependencies; every other file of the block imports this package.
package slh_pkg;

  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 64;
  localparam int PCT_W   = 7;
  localparam int FUNC_W  = 2;
  localparam int NUM_PCT = 4;
  localparam int MUL_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_SEND   = 2'd0,
    FN_RECV   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_REPORT = 2'd3
  } func_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam cnt_t CNT_MAX = '1;

  // Percentile points, in percent, in the order of the result fields.
  localparam logic [MUL_W-1:0] PCT_TAB [NUM_PCT] = '{7'd25, 7'd50, 7'd75, 7'd99};

  // Control that travels with one bucket of the report walk.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } walk_ctl_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hdl/slot_latency_histogram_stats.sv =====
// Top level of the slot latency histogram statistics block: command decode, counters,
// histogram read-modify-write and sweeps. Depends on slh_pkg, slh_hist_ram, slh_pct_unit.
//
//   channel   ports                                     transfer
//   input     start, busy, in_func, in_*_slot           start high while busy low
//   result    out_valid, out_*_count, out_pct*_bucket   one cycle per out_valid pulse
//
// Send and any receive that leaves the histogram alone answer in the cycle after
// acceptance without raising busy. A receive that updates the histogram holds busy in
// ST_UPD for the memory read-modify-write and answers in the cycle after. Clear holds busy
// while it zeros one bucket a cycle; a report reads one bucket a cycle, waits in
// ST_DRAIN for the percentile unit and then answers. Reset runs the same clearing sweep
// with busy high. Results cannot be held off by the receiver.
module slot_latency_histogram_stats
  import slh_pkg::*;
#(
  parameter int HIST_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [SLOT_W-1:0] in_current_slot,
  input  logic [SLOT_W-1:0] in_aggregate_slot,
  input  logic [SLOT_W-1:0] in_publish_slot,
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_aggregate_count,
  output logic [CNT_W-1:0]  out_sent_count,
  output logic [CNT_W-1:0]  out_received_count,
  output logic [PCT_W-1:0]  out_pct25_bucket,
  output logic [PCT_W-1:0]  out_pct50_bucket,
  output logic [PCT_W-1:0]  out_pct75_bucket,
  output logic [PCT_W-1:0]  out_pct99_bucket
);

  localparam int IDX_W = $clog2(HIST_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HIST_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UPD   = 5'b00010,
    ST_CLR   = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  cnt_t              sent_r, sent_nxt;
  cnt_t              recv_r, recv_nxt;
  cnt_t              agg_r, agg_nxt;
  logic [SLOT_W-1:0] last_agg_r, last_agg_nxt;
  logic [SLOT_W-1:0] last_pub_r, last_pub_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              clr_rsp_r, clr_rsp_nxt;
  logic              ov_r, ov_nxt;
  cnt_t              o_agg_r, o_sent_r, o_recv_r;
  pct_t              o_pct_r [NUM_PCT];

  walk_ctl_t         wctl_r;
  logic [IDX_W-1:0]  widx_r;

  func_t             func;
  logic [SLOT_W-1:0] dly;
  logic [IDX_W-1:0]  bkt;
  logic              addr_last;
  logic              emit, emit_pct;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  cnt_t              mem_wdata, mem_rdata;
  logic              pct_done;
  logic [NUM_PCT-1:0][PCT_W-1:0] pct_val;

  assign func      = func_t'(in_func);
  assign dly       = (in_current_slot > in_publish_slot) ?
                     in_current_slot - in_publish_slot : '0;
  assign bkt       = (dly < SLOT_W'(HIST_DEPTH)) ? dly[IDX_W-1:0] : IDX_LAST;
  assign addr_last = (addr_r == IDX_LAST);

  always_comb begin
    state_nxt    = state_r;
    sent_nxt     = sent_r;
    recv_nxt     = recv_r;
    agg_nxt      = agg_r;
    last_agg_nxt = last_agg_r;
    last_pub_nxt = last_pub_r;
    addr_nxt     = addr_r;
    clr_rsp_nxt  = clr_rsp_r;
    emit         = 1'b0;
    emit_pct     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = addr_r;
    mem_we       = 1'b0;
    mem_wdata    = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (func)
            FN_SEND: begin
              sent_nxt = sat_inc(sent_r);
              emit     = 1'b1;
            end
            FN_RECV: begin
              if (sent_r != '0) begin
                if (in_aggregate_slot != last_agg_r) begin
                  agg_nxt      = sat_inc(agg_r);
                  last_agg_nxt = in_aggregate_slot;
                end
                if (in_publish_slot != last_pub_r) begin
                  recv_nxt     = sat_inc(recv_r);
                  last_pub_nxt = in_publish_slot;
                end
                // The bucket is only touched once a publish slot has been seen.
                if (last_pub_r != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = bkt;
                  addr_nxt  = bkt;
                  state_nxt = ST_UPD;
                end else begin
                  emit = 1'b1;
                end
              end else begin
                emit = 1'b1;
              end
            end
            FN_CLEAR: begin
              sent_nxt     = '0;
              recv_nxt     = '0;
              agg_nxt      = '0;
              last_agg_nxt = '0;
              last_pub_nxt = '0;
              addr_nxt     = '0;
              clr_rsp_nxt  = 1'b1;
              state_nxt    = ST_CLR;
            end
            FN_REPORT: begin
              addr_nxt  = '0;
              state_nxt = ST_WALK;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = sat_inc(mem_rdata);
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_last) begin
          emit        = clr_rsp_r;
          clr_rsp_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_WALK: begin
        mem_re   = 1'b1;
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pct_done) begin
          emit      = 1'b1;
          emit_pct  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mem_waddr = addr_r;
  assign ov_nxt    = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      sent_r     <= '0;
      recv_r     <= '0;
      agg_r      <= '0;
      last_agg_r <= '0;
      last_pub_r <= '0;
      addr_r     <= '0;
      clr_rsp_r  <= 1'b0;
      ov_r       <= 1'b0;
      wctl_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      sent_r     <= sent_nxt;
      recv_r     <= recv_nxt;
      agg_r      <= agg_nxt;
      last_agg_r <= last_agg_nxt;
      last_pub_r <= last_pub_nxt;
      addr_r     <= addr_nxt;
      clr_rsp_r  <= clr_rsp_nxt;
      ov_r       <= ov_nxt;
      wctl_r.vld   <= (state_r == ST_WALK);
      wctl_r.first <= (addr_r == '0);
      wctl_r.last  <= addr_last;
    end
  end

  // Result payload and the bucket index that rides along with the read data.
  always_ff @(posedge clk) begin
    widx_r <= addr_r;
    if (emit) begin
      o_agg_r  <= agg_nxt;
      o_sent_r <= sent_nxt;
      o_recv_r <= recv_nxt;
      for (int j = 0; j < NUM_PCT; j++) begin
        o_pct_r[j] <= emit_pct ? pct_val[j] : '0;
      end
    end
  end

  slh_hist_ram #(
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slh_pct_unit #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_pct_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .agg_total (agg_r),
    .ctl       (wctl_r),
    .idx       (widx_r),
    .rd_data   (mem_rdata),
    .done      (pct_done),
    .pct       (pct_val)
  );

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = ov_r;
  assign out_aggregate_count = o_agg_r;
  assign out_sent_count      = o_sent_r;
  assign out_received_count  = o_recv_r;
  assign out_pct25_bucket    = o_pct_r[0];
  assign out_pct50_bucket    = o_pct_r[1];
  assign out_pct75_bucket    = o_pct_r[2];
  assign out_pct99_bucket    = o_pct_r[3];

endmodule

// ===== hdl/slh_hist_ram.sv =====
// Histogram storage: one write port and one read port, read data registered.
// Depends on slh_pkg for the counter type.
module slh_hist_ram
  import slh_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cnt_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cnt_t          rdata
);

  cnt_t mem [DEPTH];
  cnt_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/slh_pct_unit.sv =====
// Percentile search: accumulates buckets as they stream out of the histogram memory
// and records the first bucket that reaches each percentile. Depends on slh_pkg.
module slh_pct_unit
  import slh_pkg::*;
#(
  parameter int HIST_DEPTH = 64,
  localparam int IDX_W = $clog2(HIST_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cnt_t                          agg_total,
  input  walk_ctl_t                     ctl,
  input  logic [IDX_W-1:0]              idx,
  input  cnt_t                          rd_data,
  output logic                          done,
  output logic [NUM_PCT-1:0][PCT_W-1:0] pct
);

  localparam int   CUM_W  = CNT_W + IDX_W + 1;
  localparam int   SCL_W  = CUM_W + MUL_W;
  localparam pct_t NB_PCT = pct_t'(HIST_DEPTH);

  logic [SCL_W-1:0] thr_r [NUM_PCT];
  walk_ctl_t        ctl1_r, ctl2_r;
  logic [IDX_W-1:0] idx1_r, idx2_r;
  logic [CUM_W-1:0] cum_r;
  logic [SCL_W-1:0] scl_r;
  logic [NUM_PCT-1:0] found_r, found_nxt, hit;
  logic [IDX_W-1:0] q_r [NUM_PCT];
  logic             done_r;

  // The aggregate count does not move while a report runs, so the thresholds
  // are simply refreshed every cycle.
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_PCT; j++) begin
      thr_r[j] <= SCL_W'(agg_total) * SCL_W'(PCT_TAB[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_PCT; j++) begin
      found_nxt[j] = ctl2_r.first ? 1'b0 : found_r[j];
      hit[j]       = !found_nxt[j] && (scl_r >= thr_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      found_r <= '0;
      done_r  <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.vld && ctl2_r.last;
      if (ctl2_r.vld) begin
        found_r <= found_nxt | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx;
    idx2_r <= idx1_r;
    if (ctl.vld) begin
      cum_r <= (ctl.first ? '0 : cum_r) + CUM_W'(rd_data);
    end
    // Scale by one hundred with shifts: 64 + 32 + 4.
    scl_r <= (SCL_W'(cum_r) << 6) + (SCL_W'(cum_r) << 5) + (SCL_W'(cum_r) << 2);
    for (int j = 0; j < NUM_PCT; j++) begin
      if (ctl2_r.vld && hit[j]) begin
        q_r[j] <= idx2_r;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_PCT; j++) begin
      pct[j] = found_r[j] ? pct_t'({{PCT_W{1'b0}}, q_r[j]}) : NB_PCT;
    end
  end

  assign done = done_r;

endmodule

// ===== hdl/slh_checker.sv =====
// Port-level checks for slot_latency_histogram_stats, attached with a bind.
// Depends on slh_pkg for the command codes.
module slh_checker
  import slh_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic [CNT_W-1:0]  out_aggregate_count,
  input logic [CNT_W-1:0]  out_sent_count,
  input logic [CNT_W-1:0]  out_received_count
);

  // Reset always starts the clearing sweep of the histogram.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // A send transaction is answered in the next cycle.
  a_send_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FN_SEND) |=> out_valid)
    else $error("send transaction not answered in the next cycle");

  // Every result follows an accepted transaction or a busy period.
  a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a pending transaction");

  // Receives are ignored until a send, so no receive or aggregate counts without sends.
  a_send_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sent_count == '0) |->
      (out_received_count == '0 && out_aggregate_count == '0))
    else $error("receive counted before any send");

endmodule

bind slot_latency_histogram_stats slh_checker u_slh_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_func             (in_func),
  .out_valid           (out_valid),
  .out_aggregate_count (out_aggregate_count),
  .out_sent_count      (out_sent_count),
  .out_received_count  (out_received_count)
);

// ===== tb/slot_latency_histogram_stats_tb.sv =====
// Self-checking testbench for slot_latency_histogram_stats: directed and random commands,
// a cycle-accurate-free statistics predictor and a result scoreboard. Depends on slh_pkg.
module slot_latency_histogram_stats_tb
  import slh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB          = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_GAPS   = 50;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    func_t      op;
    slot_t      cur;
    slot_t      agg;
    slot_t      pub;
    logic [2:0] gap;
    logic       drain;
  } cmd_t;

  typedef struct packed {
    cnt_t agg_cnt;
    cnt_t sent_cnt;
    cnt_t recv_cnt;
    pct_t p25;
    pct_t p50;
    pct_t p75;
    pct_t p99;
  } stats_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [SLOT_W-1:0] in_current_slot = '0;
  logic [SLOT_W-1:0] in_aggregate_slot = '0;
  logic [SLOT_W-1:0] in_publish_slot = '0;
  logic              out_valid;
  logic [CNT_W-1:0]  out_aggregate_count;
  logic [CNT_W-1:0]  out_sent_count;
  logic [CNT_W-1:0]  out_received_count;
  logic [PCT_W-1:0]  out_pct25_bucket;
  logic [PCT_W-1:0]  out_pct50_bucket;
  logic [PCT_W-1:0]  out_pct75_bucket;
  logic [PCT_W-1:0]  out_pct99_bucket;

  slot_latency_histogram_stats #(.HIST_DEPTH(NB)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_current_slot    (in_current_slot),
    .in_aggregate_slot  (in_aggregate_slot),
    .in_publish_slot    (in_publish_slot),
    .out_valid          (out_valid),
    .out_aggregate_count(out_aggregate_count),
    .out_sent_count     (out_sent_count),
    .out_received_count (out_received_count),
    .out_pct25_bucket   (out_pct25_bucket),
    .out_pct50_bucket   (out_pct50_bucket),
    .out_pct75_bucket   (out_pct75_bucket),
    .out_pct99_bucket   (out_pct99_bucket)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted block state.
  cnt_t        sent_tot;
  cnt_t        recv_tot;
  cnt_t        agg_tot;
  slot_t       last_agg;
  slot_t       last_pub;
  cnt_t        delay_hist [NB];
  int unsigned pct_pts [4] = '{25, 50, 75, 99};

  cmd_t   pending_cmds [$];
  stats_t expected_stats [$];

  bit          took;
  bit          gaps_on;
  bit          drain_next;
  bit          gap_taken;
  int unsigned idle_left;
  int unsigned stall_cnt;
  int unsigned n_cmds;
  int unsigned n_acc;
  int unsigned n_rsp;
  int unsigned n_err;
  int unsigned n_reports;
  int unsigned n_clears;
  int unsigned n_hist_upd;

  function automatic cnt_t sat_bump(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic slot_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one command to the predicted state and returns the statistics it produces.
  function automatic stats_t next_stats(input func_t op, input slot_t cur, input slot_t agg,
                                        input slot_t pub);
    stats_t r;
    slot_t  dly;
    logic [63:0] cum;
    pct_t   q [4];
    int     b;
    int     j;
    for (j = 0; j < 4; j++) q[j] = '0;
    j   = 0;
    cum = '0;
    case (op)
      FN_SEND: sent_tot = sat_bump(sent_tot);
      FN_RECV: begin
        if (sent_tot != 0) begin
          if (last_pub != 0) begin
            dly = (cur > pub) ? cur - pub : '0;
            b = (dly < NB) ? int'(dly) : NB - 1;
            delay_hist[b] = sat_bump(delay_hist[b]);
            n_hist_upd++;
          end
          if (agg != last_agg) begin
            agg_tot  = sat_bump(agg_tot);
            last_agg = agg;
          end
          if (pub != last_pub) begin
            recv_tot = sat_bump(recv_tot);
            last_pub = pub;
          end
        end
      end
      FN_CLEAR: begin
        sent_tot = '0;
        recv_tot = '0;
        agg_tot  = '0;
        last_agg = '0;
        last_pub = '0;
        for (b = 0; b < NB; b++) delay_hist[b] = '0;
        n_clears++;
      end
      default: begin
        // Several percentiles may be crossed by the same bucket.
        for (b = 0; b < NB && j < 4; b++) begin
          cum += delay_hist[b];
          while (j < 4 && cum * 100 >= pct_pts[j] * agg_tot) begin
            q[j] = pct_t'(b);
            j++;
          end
        end
        for (; j < 4; j++) q[j] = pct_t'(NB);
        n_reports++;
      end
    endcase
    r.agg_cnt  = agg_tot;
    r.sent_cnt = sent_tot;
    r.recv_cnt = recv_tot;
    r.p25      = q[0];
    r.p50      = q[1];
    r.p75      = q[2];
    r.p99      = q[3];
    return r;
  endfunction

  task automatic add_cmd(input func_t op, input slot_t cur, input slot_t agg,
                         input slot_t pub);
    cmd_t c;
    c.op    = op;
    c.cur   = cur;
    c.agg   = agg;
    c.pub   = pub;
    c.gap   = (gaps_on && $urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 4)) : 3'd0;
    c.drain = drain_next;
    drain_next = 1'b0;
    pending_cmds.push_back(c);
    n_cmds++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // Driver: at most one nonblocking update of start per falling edge.
  always @(negedge clk) begin : drive
    cmd_t nx;
    if (rst_n) begin
      if (start && !took) begin
        // Transaction still waiting for the block.
      end else if (idle_left != 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain && expected_stats.size() != 0)) begin
        start <= 1'b0;
      end else if (pending_cmds[0].gap != 0 && !gap_taken) begin
        idle_left = pending_cmds[0].gap - 1;
        gap_taken = 1'b1;
        start <= 1'b0;
      end else begin
        nx = pending_cmds.pop_front();
        gap_taken = 1'b0;
        start             <= 1'b1;
        in_func           <= nx.op;
        in_current_slot   <= nx.cur;
        in_aggregate_slot <= nx.agg;
        in_publish_slot   <= nx.pub;
      end
    end
  end

  // Monitor, scoreboard and watchdog.
  always @(posedge clk) begin : watch
    stats_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_stats.size() == 0) begin
          $error("result seen with no transaction pending");
          n_err++;
        end else begin
          want = expected_stats.pop_front();
          cmp_field("aggregate_count", want.agg_cnt, out_aggregate_count);
          cmp_field("sent_count", want.sent_cnt, out_sent_count);
          cmp_field("received_count", want.recv_cnt, out_received_count);
          cmp_field("pct25_bucket", want.p25, out_pct25_bucket);
          cmp_field("pct50_bucket", want.p50, out_pct50_bucket);
          cmp_field("pct75_bucket", want.p75, out_pct75_bucket);
          cmp_field("pct99_bucket", want.p99, out_pct99_bucket);
          n_rsp++;
        end
      end
      took = start && (busy === 1'b0);
      if (took) begin
        expected_stats.push_back(next_stats(func_t'(in_func), in_current_slot,
                                            in_aggregate_slot, in_publish_slot));
        n_acc++;
      end
      if (took || out_valid === 1'b1) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Watchdog expired: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    slot_t       base;
    slot_t       cur;
    slot_t       agg;
    slot_t       pub;
    int unsigned r;
    bit          drained;
    int          k;

    sent_tot = '0;
    recv_tot = '0;
    agg_tot  = '0;
    last_agg = '0;
    last_pub = '0;
    for (k = 0; k < NB; k++) delay_hist[k] = '0;
    drained = 1'b0;

    // Directed commands.
    gaps_on = 1'b0;
    add_cmd(FN_REPORT, '0, '0, '0);                // no aggregates yet: all buckets zero
    add_cmd(FN_RECV, 64'd100, 64'd5, 64'd90);      // ignored, nothing sent
    add_cmd(FN_SEND, '0, '0, '0);
    add_cmd(FN_RECV, 64'd100, 64'd5, 64'd90);      // first publish slot, no histogram hit
    add_cmd(FN_REPORT, '0, '0, '0);                // percentiles never reached
    add_cmd(FN_RECV, 64'd93, 64'd5, 64'd90);       // delay 3, slots unchanged
    add_cmd(FN_RECV, 64'd80, 64'd6, 64'd95);       // current behind publish: delay 0
    add_cmd(FN_RECV, 64'd158, 64'd6, 64'd95);      // delay 63
    add_cmd(FN_RECV, 64'd159, 64'd6, 64'd95);      // delay 64 clamps
    add_cmd(FN_RECV, '1, '1, 64'd1);               // huge delay
    add_cmd(FN_REPORT, '1, '1, '1);
    add_cmd(FN_RECV, 64'd50, 64'd7, '0);           // publish slot returns to zero
    add_cmd(FN_RECV, 64'd10, 64'd7, '0);           // no histogram hit after that
    add_cmd(FN_REPORT, '0, '0, '0);
    add_cmd(FN_CLEAR, '1, '1, '1);
    add_cmd(FN_REPORT, '0, '0, '0);
    add_cmd(FN_RECV, 64'd9, 64'd8, 64'd4);         // ignored again after clear
    add_cmd(FN_SEND, '1, '1, '1);
    add_cmd(FN_RECV, '0, '0, '0);
    add_cmd(FN_RECV, '1, '1, '1);
    add_cmd(FN_RECV, '1, '0, '1);
    add_cmd(FN_REPORT, '0, '0, '0);
    drain_next = 1'b1;

    // Random sessions: optional clear, sends, mostly receives around a base slot, a report.
    while (n_cmds < 550) begin
      gaps_on = (n_cmds < 550 - TAIL_GAPS) && ($urandom_range(0, 3) != 0);
      if (!drained && n_cmds > 275) begin
        drain_next = 1'b1;
        drained    = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        add_cmd(FN_CLEAR, rand64(), rand64(), rand64());
        repeat ($urandom_range(0, 3)) add_cmd(FN_SEND, rand64(), rand64(), rand64());
      end else begin
        repeat ($urandom_range(1, 3)) add_cmd(FN_SEND, rand64(), rand64(), rand64());
      end
      case ($urandom_range(0, 3))
        0: base = rand64();
        1: base = slot_t'($urandom_range(1, 1000));
        2: base = '1 - slot_t'($urandom_range(0, 100));
        default: base = rand64() >> $urandom_range(0, 63);
      endcase
      pub = base;
      agg = base + slot_t'($urandom_range(0, 2));
      repeat ($urandom_range(5, 30)) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          add_cmd(func_t'($urandom_range(0, 3)), rand64(), rand64(), rand64());
        end else if (r == 1) begin
          add_cmd(FN_SEND, rand64(), rand64(), rand64());
        end else if (r == 2) begin
          add_cmd(FN_REPORT, rand64(), rand64(), rand64());
        end else begin
          if ($urandom_range(0, 2) != 0) pub = pub + slot_t'($urandom_range(1, 3));
          else if ($urandom_range(0, 15) == 0) pub = '0;
          if ($urandom_range(0, 3) != 0) agg = agg + slot_t'($urandom_range(1, 2));
          case ($urandom_range(0, 9))
            0: cur = pub - slot_t'($urandom_range(1, 5));
            1: cur = rand64();
            2, 3: cur = pub + slot_t'($urandom_range(0, 80));
            default: cur = pub + slot_t'($urandom_range(0, 8));
          endcase
          add_cmd(FN_RECV, cur, agg, pub);
        end
      end
      add_cmd(FN_REPORT, rand64(), rand64(), rand64());
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (NB + 8) @(posedge clk);

    $display("Ran %0d commands with %0d results: %0d reports, %0d clears,", n_acc, n_rsp,
             n_reports, n_clears);
    $display("and %0d histogram updates across sessions of varied slot ranges.", n_hist_upd);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
